// ===== src/assert_macros.svh =====
// Assertion helpers shared by the compositor modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/psc_pkg.sv =====
package psc_pkg;

  localparam int unsigned PERMILLE    = 1000;
  localparam int unsigned STR_MAX     = 2000;
  localparam int unsigned CHAN_MAX    = 255;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned NUM_STAGES  = 9;
  localparam int unsigned STG_MEM     = 5;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_INDEX_W = 3;

  // Division by 1000 as a multiply by a rounded-up reciprocal. Exact for
  // every numerator below 2^28 / 544, which covers 255 * 1000.
  localparam int unsigned RECIP_SHIFT = 28;
  localparam int unsigned RECIP_MUL   = ((1 << RECIP_SHIFT) + PERMILLE - 1) / PERMILLE;

  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BRIGHTNESS,
    REG_RED_STR,
    REG_GREEN_STR,
    REG_BLUE_STR,
    REG_OPACITY,
    REG_ADD_MODE,
    REG_PAL_OFFSET
  } reg_idx_t;

  typedef enum logic [2:0] {
    MIX_NONE,
    MIX_ADD_LO,
    MIX_ADD_HI,
    MIX_COPY,
    MIX_BLEND
  } mix_t;

  typedef struct packed {
    logic [9:0]                    bright;
    logic [NUM_CHAN-1:0]           dark;
    logic [NUM_CHAN-1:0][9:0]      str_fac;
    logic [7:0]                    offset;
    mix_t                          mix;
    logic [9:0]                    op_a;
    logic [9:0]                    op_b;
  } cfg_t;

  typedef struct packed {
    logic                          func;
    logic                          transp;
    logic [7:0]                    addr;
    logic [NUM_CHAN-1:0][7:0]      dest;
  } meta_t;

  function automatic logic [7:0] div_permille(input logic [17:0] num);
    logic [36:0] prod;
    prod = 37'(num) * 37'(RECIP_MUL);
    return prod[RECIP_SHIFT +: 8];
  endfunction

endpackage

// ===== src/palette_sprite_compositor.sv =====
// Palette sprite compositor.
// Input channel (in_valid / in_stall): one transaction is either a palette
// write (in_func low: in_index selects the entry, in_entry_* give its raw
// color) or a pixel (in_func high: in_index is the source color index and
// in_dest_* hold the current frame buffer color).
// Output channel (out_valid / out_stall): exactly one transaction per input
// transaction, in order. out_write_enable tells whether the frame buffer
// pixel has to be written with out_red, out_green, out_blue and out_alpha.
// Configuration port: cfg_write_enable, cfg_index and cfg_data write one
// register per cycle; the user must use it only while no transaction is in
// flight, which the block does not enforce. Results leave through the output
// register of the last stage; throughput is one transaction per cycle unless
// stalled, set by the single-ported palette, accessed once per transaction.
// When the receiver stalls, the output holds and the pipeline keeps
// accepting until every stage is full; only then does in_stall rise.
// Reset clears the valid pipeline and loads the register defaults. The
// palette memory is not cleared; entries read back only after a write.
`include "assert_macros.svh"

module palette_sprite_compositor (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_write_enable,
  input  logic [psc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [7:0]                         in_index,
  input  logic [7:0]                         in_entry_red,
  input  logic [7:0]                         in_entry_green,
  input  logic [7:0]                         in_entry_blue,
  input  logic [7:0]                         in_entry_alpha,
  input  logic [7:0]                         in_dest_red,
  input  logic [7:0]                         in_dest_green,
  input  logic [7:0]                         in_dest_blue,
  input  logic [7:0]                         in_dest_alpha,
  // Output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_write_enable,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha
);

  localparam int unsigned NS = psc_pkg::NUM_STAGES;

  psc_pkg::cfg_t        cfg;
  psc_pkg::stage_vec_t  vld_r, vld_nxt;
  psc_pkg::stage_vec_t  rdy;
  psc_pkg::meta_t       meta5;
  logic [31:0]          entry5;
  logic [31:0]          rdata;
  logic                 mem_go;
  logic                 mem_wr;
  logic                 mem_rd;

  // A stage may load when it is empty or its occupant moves on. The
  // destination alpha does not affect any result and is not carried.
  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NS-1];

  // The palette is touched once, as a transaction enters the memory stage.
  // Palette writes and pixel reads meet the memory in transaction order, so
  // a pixel always sees every palette write that was accepted before it.
  assign mem_go = rdy[psc_pkg::STG_MEM] && vld_r[psc_pkg::STG_MEM-1];
  assign mem_wr = mem_go && (meta5.func == psc_pkg::FUNC_PALETTE);
  assign mem_rd = mem_go && (meta5.func == psc_pkg::FUNC_PIXEL);

  psc_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  psc_cond u_cond (
    .clk            (clk),
    .ld             (rdy),
    .cfg            (cfg),
    .in_func        (in_func),
    .in_index       (in_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .in_entry_alpha (in_entry_alpha),
    .in_dest_red    (in_dest_red),
    .in_dest_green  (in_dest_green),
    .in_dest_blue   (in_dest_blue),
    .meta5          (meta5),
    .entry5         (entry5)
  );

  psc_pal_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (mem_wr),
    .rd_en (mem_rd),
    .addr  (meta5.addr),
    .wdata (entry5),
    .rdata (rdata)
  );

  psc_blend u_blend (
    .clk              (clk),
    .rst_n            (rst_n),
    .ld               (rdy),
    .cfg              (cfg),
    .meta5            (meta5),
    .rdata            (rdata),
    .out_write_enable (out_write_enable),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha)
  );

  `PSC_ASSERT_SAME(a_full_blocks_input, (&vld_r) && out_stall, in_stall, "input taken into a full stalled pipeline")

endmodule

// ===== src/psc_cfg.sv =====
`include "assert_macros.svh"

module psc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_enable,
  input  logic [psc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output psc_pkg::cfg_t                      cfg
);

  logic [9:0]                             brightness_r, brightness_nxt;
  logic [psc_pkg::NUM_CHAN-1:0][10:0]     str_r, str_nxt;
  logic [10:0]                            opacity_r, opacity_nxt;
  logic                                   add_r, add_nxt;
  logic [7:0]                             offset_r, offset_nxt;

  // Range clamps are applied as a register is written.
  always_comb begin
    brightness_nxt = brightness_r;
    str_nxt        = str_r;
    opacity_nxt    = opacity_r;
    add_nxt        = add_r;
    offset_nxt     = offset_r;
    if (cfg_write_enable) begin
      unique case (psc_pkg::reg_idx_t'(cfg_index))
        psc_pkg::REG_BRIGHTNESS: begin
          brightness_nxt = (cfg_data[9:0] > 10'(psc_pkg::PERMILLE)) ?
                           10'(psc_pkg::PERMILLE) : cfg_data[9:0];
        end
        psc_pkg::REG_RED_STR: begin
          str_nxt[0] = (cfg_data > 11'(psc_pkg::STR_MAX)) ? 11'(psc_pkg::STR_MAX) : cfg_data;
        end
        psc_pkg::REG_GREEN_STR: begin
          str_nxt[1] = (cfg_data > 11'(psc_pkg::STR_MAX)) ? 11'(psc_pkg::STR_MAX) : cfg_data;
        end
        psc_pkg::REG_BLUE_STR: begin
          str_nxt[2] = (cfg_data > 11'(psc_pkg::STR_MAX)) ? 11'(psc_pkg::STR_MAX) : cfg_data;
        end
        psc_pkg::REG_OPACITY: begin
          opacity_nxt = (cfg_data > 11'(psc_pkg::STR_MAX)) ? 11'(psc_pkg::STR_MAX) : cfg_data;
        end
        psc_pkg::REG_ADD_MODE: begin
          add_nxt = cfg_data[0];
        end
        psc_pkg::REG_PAL_OFFSET: begin
          offset_nxt = cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 10'(psc_pkg::PERMILLE);
      str_r        <= {psc_pkg::NUM_CHAN{11'(psc_pkg::PERMILLE)}};
      opacity_r    <= 11'(psc_pkg::PERMILLE);
      add_r        <= 1'b0;
      offset_r     <= 8'd0;
    end else begin
      brightness_r <= brightness_nxt;
      str_r        <= str_nxt;
      opacity_r    <= opacity_nxt;
      add_r        <= add_nxt;
      offset_r     <= offset_nxt;
    end
  end

  // Derived factors: strength reduces to a flag and one operand, opacity to a
  // mix mode and up to two operands; the datapath never sees the raw values.
  always_comb begin
    cfg.bright = brightness_r;
    cfg.offset = offset_r;
    for (int c = 0; c < psc_pkg::NUM_CHAN; c++) begin
      cfg.dark[c]    = str_r[c] < 11'(psc_pkg::PERMILLE);
      cfg.str_fac[c] = cfg.dark[c] ? 10'(11'(psc_pkg::PERMILLE) - str_r[c]) :
                                     10'(str_r[c] - 11'(psc_pkg::PERMILLE));
    end
    cfg.op_a = 10'd0;
    cfg.op_b = 10'd0;
    if (add_r) begin
      if (opacity_r <= 11'(psc_pkg::PERMILLE)) begin
        cfg.mix  = psc_pkg::MIX_ADD_LO;
        cfg.op_a = opacity_r[9:0];
      end else begin
        cfg.mix  = psc_pkg::MIX_ADD_HI;
        cfg.op_a = 10'(opacity_r - 11'(psc_pkg::PERMILLE));
      end
    end else if (opacity_r >= 11'(psc_pkg::PERMILLE)) begin
      cfg.mix = psc_pkg::MIX_COPY;
    end else if (opacity_r == 11'd0) begin
      cfg.mix = psc_pkg::MIX_NONE;
    end else begin
      cfg.mix  = psc_pkg::MIX_BLEND;
      cfg.op_a = opacity_r[9:0];
      cfg.op_b = 10'(11'(psc_pkg::PERMILLE) - opacity_r);
    end
  end

  `PSC_ASSERT_NEXT(a_bright_clamp, cfg_write_enable && (cfg_index == psc_pkg::REG_BRIGHTNESS) && (cfg_data[9:0] > 10'(psc_pkg::PERMILLE)), brightness_r == 10'(psc_pkg::PERMILLE), "brightness not clamped")

endmodule

// ===== src/psc_cond.sv =====
module psc_cond (
  input  logic                  clk,
  input  psc_pkg::stage_vec_t   ld,
  input  psc_pkg::cfg_t         cfg,
  input  logic                  in_func,
  input  logic [7:0]            in_index,
  input  logic [7:0]            in_entry_red,
  input  logic [7:0]            in_entry_green,
  input  logic [7:0]            in_entry_blue,
  input  logic [7:0]            in_entry_alpha,
  input  logic [7:0]            in_dest_red,
  input  logic [7:0]            in_dest_green,
  input  logic [7:0]            in_dest_blue,
  output psc_pkg::meta_t        meta5,
  output logic [31:0]           entry5
);

  localparam int unsigned NC = psc_pkg::NUM_CHAN;

  psc_pkg::meta_t           meta_in;
  psc_pkg::meta_t           meta_r [5];
  logic [7:0]               alpha_r [4];
  logic [NC-1:0][7:0]       ch1_r;
  logic [NC-1:0][17:0]      prod_b, prod_b_r;
  logic [NC-1:0][7:0]       bv, bv3_r, bv4_r;
  logic [NC-1:0][7:0]       operand;
  logic [NC-1:0][17:0]      push_prod, push_r;
  logic [NC-1:0][7:0]       q, res;
  logic [31:0]              entry_r;

  // A palette write addresses the store directly; a pixel goes through the
  // palette offset.
  always_comb begin
    meta_in.func   = in_func;
    meta_in.transp = (in_index == 8'd0);
    meta_in.addr   = (in_func == psc_pkg::FUNC_PIXEL) ? in_index + cfg.offset : in_index;
    meta_in.dest   = {in_dest_blue, in_dest_green, in_dest_red};
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      prod_b[c]    = 18'(ch1_r[c]) * 18'(cfg.bright);
      bv[c]        = psc_pkg::div_permille(prod_b_r[c]);
      operand[c]   = cfg.dark[c] ? bv3_r[c] : 8'(psc_pkg::CHAN_MAX) - bv3_r[c];
      push_prod[c] = 18'(operand[c]) * 18'(cfg.str_fac[c]);
      q[c]         = psc_pkg::div_permille(push_r[c]);
      res[c]       = cfg.dark[c] ? bv4_r[c] - q[c] : bv4_r[c] + q[c];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      meta_r[0]  <= meta_in;
      alpha_r[0] <= in_entry_alpha;
      ch1_r      <= {in_entry_blue, in_entry_green, in_entry_red};
    end
    for (int k = 1; k < 5; k++) begin
      if (ld[k]) begin
        meta_r[k] <= meta_r[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (ld[k]) begin
        alpha_r[k] <= alpha_r[k-1];
      end
    end
    if (ld[1]) begin
      prod_b_r <= prod_b;
    end
    if (ld[2]) begin
      bv3_r <= bv;
    end
    if (ld[3]) begin
      bv4_r  <= bv3_r;
      push_r <= push_prod;
    end
    if (ld[4]) begin
      entry_r <= {res[0], res[1], res[2], alpha_r[3]};
    end
  end

  assign meta5  = meta_r[4];
  assign entry5 = entry_r;

endmodule

// ===== src/psc_pal_mem.sv =====
`include "assert_macros.svh"

module psc_pal_mem (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic         rd_en,
  input  logic [7:0]   addr,
  input  logic [31:0]  wdata,
  output logic [31:0]  rdata
);

  logic [31:0] mem [256];
  logic [31:0] rdata_r;

  // Read data only changes on a read, so a held stage keeps its entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

  `PSC_ASSERT_SAME(a_single_access, wr_en, !rd_en, "palette read and write in one cycle")

endmodule

// ===== src/psc_blend.sv =====
`include "assert_macros.svh"

module psc_blend (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psc_pkg::stage_vec_t   ld,
  input  psc_pkg::cfg_t         cfg,
  input  psc_pkg::meta_t        meta5,
  input  logic [31:0]           rdata,
  output logic                  out_write_enable,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha
);

  localparam int unsigned NC = psc_pkg::NUM_CHAN;

  psc_pkg::meta_t          meta6_r;
  psc_pkg::mix_t           mix6, mix7_r, mix8_r;
  logic [NC-1:0][7:0]      src6;
  logic [NC-1:0][17:0]     num6, num7_r;
  logic [NC-1:0][7:0]      src7_r, dest7_r, src8_r, dest8_r, q8;
  logic [7:0]              sa7_r, sa8_r;
  logic [NC-1:0][7:0]      q8_r;
  logic [NC-1:0][9:0]      sum;
  logic [NC-1:0][7:0]      res;
  logic                    we;
  logic [7:0]              alpha;
  logic                    we_r;
  logic [NC-1:0][7:0]      col_r;
  logic [7:0]              alpha_r;

  always_comb begin
    src6 = {rdata[15:8], rdata[23:16], rdata[31:24]};
    if (meta6_r.func == psc_pkg::FUNC_PALETTE || meta6_r.transp) begin
      mix6 = psc_pkg::MIX_NONE;
    end else begin
      mix6 = cfg.mix;
    end
    for (int c = 0; c < NC; c++) begin
      case (mix6)
        psc_pkg::MIX_ADD_LO: num6[c] = 18'(src6[c]) * 18'(cfg.op_a);
        psc_pkg::MIX_ADD_HI: num6[c] = 18'(8'(psc_pkg::CHAN_MAX) - src6[c]) * 18'(cfg.op_a);
        psc_pkg::MIX_BLEND:  num6[c] = 18'(src6[c]) * 18'(cfg.op_a) +
                                       18'(meta6_r.dest[c]) * 18'(cfg.op_b);
        default:             num6[c] = 18'd0;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      q8[c] = psc_pkg::div_permille(num7_r[c]);
    end
  end

  // Final select, with saturation at full scale in the additive modes.
  always_comb begin
    we    = 1'b1;
    alpha = 8'(psc_pkg::CHAN_MAX);
    for (int c = 0; c < NC; c++) begin
      sum[c] = 10'(dest8_r[c]) + 10'(q8_r[c]);
      if (mix8_r == psc_pkg::MIX_ADD_HI) begin
        sum[c] = sum[c] + 10'(src8_r[c]);
      end
      case (mix8_r) inside
        psc_pkg::MIX_ADD_LO, psc_pkg::MIX_ADD_HI: begin
          res[c] = (sum[c] > 10'(psc_pkg::CHAN_MAX)) ? 8'(psc_pkg::CHAN_MAX) : sum[c][7:0];
        end
        psc_pkg::MIX_COPY:  res[c] = src8_r[c];
        psc_pkg::MIX_BLEND: res[c] = q8_r[c];
        default:            res[c] = 8'd0;
      endcase
    end
    case (mix8_r)
      psc_pkg::MIX_COPY: alpha = sa8_r;
      psc_pkg::MIX_NONE: begin
        we    = 1'b0;
        alpha = 8'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      meta6_r <= meta5;
    end
    if (ld[6]) begin
      mix7_r  <= mix6;
      num7_r  <= num6;
      src7_r  <= src6;
      sa7_r   <= rdata[7:0];
      dest7_r <= meta6_r.dest;
    end
    if (ld[7]) begin
      mix8_r  <= mix7_r;
      q8_r    <= q8;
      src8_r  <= src7_r;
      sa8_r   <= sa7_r;
      dest8_r <= dest7_r;
    end
    if (ld[8]) begin
      we_r    <= we;
      col_r   <= res;
      alpha_r <= alpha;
    end
  end

  assign out_write_enable = we_r;
  assign out_red          = col_r[0];
  assign out_green        = col_r[1];
  assign out_blue         = col_r[2];
  assign out_alpha        = alpha_r;

  `PSC_ASSERT_NEXT(a_silent_zero, ld[8] && (mix8_r == psc_pkg::MIX_NONE), !out_write_enable && (out_red == 8'd0) && (out_alpha == 8'd0), "suppressed result carries data")

endmodule

// ===== verif/psc_pixel_checker.sv =====
`timescale 1ns / 100ps

module psc_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_write_enable,
  input  logic [psc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_func,
  input  logic [7:0]                      in_index,
  input  logic [7:0]                      in_entry_red,
  input  logic [7:0]                      in_entry_green,
  input  logic [7:0]                      in_entry_blue,
  input  logic [7:0]                      in_entry_alpha,
  input  logic [7:0]                      in_dest_red,
  input  logic [7:0]                      in_dest_green,
  input  logic [7:0]                      in_dest_blue,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_write_enable,
  input  logic [7:0]                      out_red,
  input  logic [7:0]                      out_green,
  input  logic [7:0]                      out_blue,
  input  logic [7:0]                      out_alpha,
  output int unsigned                     mismatch_count,
  output int unsigned                     pixels_outstanding
);

  typedef struct packed {
    logic       write_enable;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_write_t;

  logic [9:0]   bright_permille;
  logic [10:0]  red_str;
  logic [10:0]  green_str;
  logic [10:0]  blue_str;
  logic [10:0]  opacity_permille;
  logic         add_blend;
  logic [7:0]   index_offset;
  logic [31:0]  palette_mem [256];
  pixel_write_t expected_pixels [$];
  int unsigned  results_seen;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    return (v > hi) ? hi : v;
  endfunction

  // Brightness scaling, then the push toward black or white.
  function automatic logic [7:0] load_channel(int unsigned raw, int unsigned strength);
    int unsigned v;
    int unsigned st;
    v  = raw * clamp_to(bright_permille, psc_pkg::PERMILLE) / psc_pkg::PERMILLE;
    st = clamp_to(strength, psc_pkg::STR_MAX);
    if (st < psc_pkg::PERMILLE) begin
      v = v - v * (psc_pkg::PERMILLE - st) / psc_pkg::PERMILLE;
    end else begin
      v = v + (psc_pkg::CHAN_MAX - v) * (st - psc_pkg::PERMILLE) / psc_pkg::PERMILLE;
    end
    return v[7:0];
  endfunction

  function automatic logic [7:0] add_channel(int unsigned dst, int unsigned src,
                                             int unsigned op);
    int unsigned amount;
    int unsigned total;
    if (op <= psc_pkg::PERMILLE) begin
      amount = src * op / psc_pkg::PERMILLE;
    end else begin
      amount = src + (psc_pkg::CHAN_MAX - src) * (op - psc_pkg::PERMILLE) /
               psc_pkg::PERMILLE;
    end
    total = clamp_to(dst + amount, psc_pkg::CHAN_MAX);
    return total[7:0];
  endfunction

  function automatic logic [7:0] mix_channel(int unsigned dst, int unsigned src,
                                             int unsigned op);
    int unsigned mixed;
    mixed = (src * op + dst * (psc_pkg::PERMILLE - op)) / psc_pkg::PERMILLE;
    return mixed[7:0];
  endfunction

  // Frame buffer write that one pixel transaction must produce.
  function automatic pixel_write_t composite_pixel(logic [7:0] src_index, logic [7:0] dr,
                                                   logic [7:0] dg, logic [7:0] db);
    pixel_write_t px;
    logic [7:0]   slot;
    logic [31:0]  color;
    int unsigned  op;
    px = '0;
    if (src_index == 8'd0) begin
      return px;
    end
    slot  = src_index + index_offset;
    color = palette_mem[slot];
    if (add_blend) begin
      op              = clamp_to(opacity_permille, psc_pkg::STR_MAX);
      px.write_enable = 1'b1;
      px.red          = add_channel(dr, color[31:24], op);
      px.green        = add_channel(dg, color[23:16], op);
      px.blue         = add_channel(db, color[15:8], op);
      px.alpha        = 8'hFF;
    end else begin
      op = clamp_to(opacity_permille, psc_pkg::PERMILLE);
      if (op == psc_pkg::PERMILLE) begin
        px.write_enable = 1'b1;
        px.red          = color[31:24];
        px.green        = color[23:16];
        px.blue         = color[15:8];
        px.alpha        = color[7:0];
      end else if (op != 0) begin
        px.write_enable = 1'b1;
        px.red          = mix_channel(dr, color[31:24], op);
        px.green        = mix_channel(dg, color[23:16], op);
        px.blue         = mix_channel(db, color[15:8], op);
        px.alpha        = 8'hFF;
      end
    end
    return px;
  endfunction

  // Prints one line for a mismatch and counts it.
  task automatic report_mismatch(string msg);
    $display("%0t psc_pixel_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  always @(posedge clk) begin : track
    pixel_write_t want;
    if (!rst_n) begin
      bright_permille  = 10'(psc_pkg::PERMILLE);
      red_str          = 11'(psc_pkg::PERMILLE);
      green_str        = 11'(psc_pkg::PERMILLE);
      blue_str         = 11'(psc_pkg::PERMILLE);
      opacity_permille = 11'(psc_pkg::PERMILLE);
      add_blend        = 1'b0;
      index_offset     = 8'd0;
      expected_pixels.delete();
      mismatch_count   = 0;
      results_seen     = 0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          psc_pkg::REG_BRIGHTNESS: bright_permille  = cfg_data[9:0];
          psc_pkg::REG_RED_STR:    red_str          = cfg_data[10:0];
          psc_pkg::REG_GREEN_STR:  green_str        = cfg_data[10:0];
          psc_pkg::REG_BLUE_STR:   blue_str         = cfg_data[10:0];
          psc_pkg::REG_OPACITY:    opacity_permille = cfg_data[10:0];
          psc_pkg::REG_ADD_MODE:   add_blend        = cfg_data[0];
          psc_pkg::REG_PAL_OFFSET: index_offset     = cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing pending",
                                    results_seen));
        end else begin
          want = expected_pixels.pop_front();
          check_field("write_enable", out_write_enable, want.write_enable);
          check_field("red", out_red, want.red);
          check_field("green", out_green, want.green);
          check_field("blue", out_blue, want.blue);
          check_field("alpha", out_alpha, want.alpha);
        end
      end

      if (in_valid && !in_stall) begin
        if (in_func == psc_pkg::FUNC_PALETTE) begin
          palette_mem[in_index] = {load_channel(in_entry_red, red_str),
                                   load_channel(in_entry_green, green_str),
                                   load_channel(in_entry_blue, blue_str),
                                   in_entry_alpha};
          expected_pixels.push_back('0);
        end else begin
          expected_pixels.push_back(composite_pixel(in_index, in_dest_red,
                                                    in_dest_green, in_dest_blue));
        end
      end
    end
    pixels_outstanding = expected_pixels.size();
  end

endmodule

// ===== verif/tb_palette_sprite_compositor.sv =====
`timescale 1ns / 100ps

module tb_palette_sprite_compositor;

  // Run shape. The directed part comes first, then a series of phases, each
  // under its own register setting. The early phases use fixed settings at the
  // extremes of every register; later phases pick settings at random.
  localparam int unsigned NUM_PHASES     = 14;
  localparam int unsigned PHASE_ITEMS    = 46;
  localparam int unsigned QUIET_PHASES   = 2;
  localparam int unsigned HOLD_PHASE     = 3;
  localparam int unsigned PAUSE_PHASE    = 5;
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned PIPE_LATENCY   = 9;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned RUN_LIMIT_NS   = 2_000_000;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_write_enable;
  logic [psc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            in_func;
  logic [7:0]                      in_index;
  logic [7:0]                      in_entry_red;
  logic [7:0]                      in_entry_green;
  logic [7:0]                      in_entry_blue;
  logic [7:0]                      in_entry_alpha;
  logic [7:0]                      in_dest_red;
  logic [7:0]                      in_dest_green;
  logic [7:0]                      in_dest_blue;
  logic [7:0]                      in_dest_alpha;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_write_enable;
  logic [7:0]                      out_red;
  logic [7:0]                      out_green;
  logic [7:0]                      out_blue;
  logic [7:0]                      out_alpha;

  int unsigned mismatches;
  int unsigned pixels_outstanding;

  // Idling control shared between the sender and the receiver. These are
  // written with nonblocking assignments at the falling edge, so the receiver
  // process always sees a change in the next cycle, never within the same step.
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;

  // The sender keeps track of which palette entries it has written, so that
  // a non-transparent pixel never looks up an entry that holds no color yet.
  logic [7:0] offset_now;
  bit         entry_written [256];
  logic [7:0] written_entries [$];

  palette_sprite_compositor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_index         (in_index),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .in_entry_alpha   (in_entry_alpha),
    .in_dest_red      (in_dest_red),
    .in_dest_green    (in_dest_green),
    .in_dest_blue     (in_dest_blue),
    .in_dest_alpha    (in_dest_alpha),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_enable (out_write_enable),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha)
  );

  // The checker watches both channels and the register port, keeps its own
  // model of the palette and the registers, and compares every result.
  psc_pixel_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_index           (in_index),
    .in_entry_red       (in_entry_red),
    .in_entry_green     (in_entry_green),
    .in_entry_blue      (in_entry_blue),
    .in_entry_alpha     (in_entry_alpha),
    .in_dest_red        (in_dest_red),
    .in_dest_green      (in_dest_green),
    .in_dest_blue       (in_dest_blue),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_write_enable   (out_write_enable),
    .out_red            (out_red),
    .out_green          (out_green),
    .out_blue           (out_blue),
    .out_alpha          (out_alpha),
    .mismatch_count     (mismatches),
    .pixels_outstanding (pixels_outstanding)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One register write per cycle. The caller is at a falling edge, and the
  // task returns at the next one, after the write has taken effect.
  task automatic write_reg(psc_pkg::reg_idx_t idx, int unsigned value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value[psc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
  endtask

  // Writes every register. It is only called while no transaction is in flight,
  // the only time the user may write a register; the block does not enforce it.
  task automatic set_config(int unsigned bright, int unsigned red, int unsigned green,
                            int unsigned blue, int unsigned opac, int unsigned add_mode,
                            int unsigned offset);
    write_reg(psc_pkg::REG_BRIGHTNESS, bright);
    write_reg(psc_pkg::REG_RED_STR, red);
    write_reg(psc_pkg::REG_GREEN_STR, green);
    write_reg(psc_pkg::REG_BLUE_STR, blue);
    write_reg(psc_pkg::REG_OPACITY, opac);
    write_reg(psc_pkg::REG_ADD_MODE, add_mode);
    write_reg(psc_pkg::REG_PAL_OFFSET, offset);
    cfg_write_enable <= 1'b0;
    offset_now = offset[7:0];
  endtask

  // Offers one transaction and holds it until it is accepted. It is entered
  // at a falling edge and returns at the falling edge after acceptance, so
  // valid can stay high without a glitch when the next call follows directly.
  task automatic send_item(logic func, logic [7:0] idx, logic [31:0] entry,
                           logic [31:0] dest);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_index <= idx;
    {in_entry_red, in_entry_green, in_entry_blue, in_entry_alpha} <= entry;
    {in_dest_red, in_dest_green, in_dest_blue, in_dest_alpha}     <= dest;
    if (func == psc_pkg::FUNC_PALETTE && !entry_written[idx]) begin
      entry_written[idx] = 1'b1;
      written_entries.push_back(idx);
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // About a third of the random transactions load the palette; the rest are
  // pixels, a few of them transparent, the others aimed through the current
  // offset at an entry that has been written.
  task automatic send_random_item();
    logic       func;
    logic [7:0] idx;
    if (written_entries.size() == 0 || $urandom_range(0, 99) < 30) begin
      func = psc_pkg::FUNC_PALETTE;
      idx  = 8'($urandom_range(0, 255));
    end else begin
      func = psc_pkg::FUNC_PIXEL;
      if ($urandom_range(0, 99) < 8) begin
        idx = 8'd0;
      end else begin
        idx = written_entries[$urandom_range(0, written_entries.size() - 1)] - offset_now;
      end
    end
    send_item(func, idx, $urandom(), $urandom());
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pixels_outstanding != 0);
  endtask

  function automatic int unsigned idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Fixed settings reach the extremes: zero brightness and strength, values
  // above every clamp, additive and blend mode at zero opacity, the smallest
  // and largest blend weights, and offsets that wrap the palette index.
  task automatic apply_setting(int unsigned phase);
    case (phase)
      0:       set_config(1000, 1000, 1000, 1000, 1000, 0, 0);
      1:       set_config(0, 0, 0, 0, 0, 0, 0);
      2:       set_config(1023, 2047, 2047, 2047, 2047, 1, 255);
      3:       set_config(1000, 2000, 0, 1999, 0, 1, 17);
      4:       set_config(500, 999, 1001, 1000, 1, 0, 1);
      5:       set_config(1000, 1000, 1000, 1000, 999, 0, 128);
      6:       set_config(777, 1500, 500, 2000, 1000, 1, 64);
      7:       set_config(1000, 1000, 1000, 1000, 1023, 0, 200);
      default: set_config($urandom_range(0, 1023), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 2047),
                          ($urandom_range(0, 2) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(1, 999),
                          $urandom_range(0, 1), $urandom_range(0, 255));
    endcase
  endtask

  // The receiver side. Random stall bursts, plus one long hold on request,
  // counted here, during which the sender keeps offering transactions until
  // the pipeline is full and the input stalls.
  initial begin : result_backpressure
    int unsigned holds_done;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned waited;
    rst_n            = 1'b0;
    cfg_write_enable = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_func          = psc_pkg::FUNC_PALETTE;
    in_index         = '0;
    {in_entry_red, in_entry_green, in_entry_blue, in_entry_alpha} = '0;
    {in_dest_red, in_dest_green, in_dest_blue, in_dest_alpha}     = '0;
    gap_pct          = 0;
    stall_pct        = 0;
    hold_requests    = 0;
    offset_now       = 8'd0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, no idling. Palette entries at both ends of the index
    // range and with extreme and alternating bit patterns, then pixels: a
    // transparent one and opaque copies of every other entry.
    set_config(1000, 1000, 1000, 1000, 1000, 0, 0);
    send_item(psc_pkg::FUNC_PALETTE, 8'd0,   32'h0000_0000, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PALETTE, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PALETTE, 8'd1,   32'hAA55_AA55, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PALETTE, 8'd2,   32'h55AA_55AA, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PALETTE, 8'd128, 32'h807F_01FE, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PIXEL,   8'd0,   32'h0000_0000, 32'hFFFF_FFFF);
    send_item(psc_pkg::FUNC_PIXEL,   8'd255, 32'h0000_0000, 32'h0000_0000);
    send_item(psc_pkg::FUNC_PIXEL,   8'd1,   32'h0000_0000, 32'hFFFF_FFFF);
    send_item(psc_pkg::FUNC_PIXEL,   8'd2,   32'h0000_0000, 32'h55AA_55AA);
    send_item(psc_pkg::FUNC_PIXEL,   8'd128, 32'h0000_0000, 32'hAA55_AA55);

    // Additive blend at the top of the opacity range saturates every channel.
    wait_for_drain();
    set_config(1000, 1000, 1000, 1000, 2000, 1, 0);
    send_item(psc_pkg::FUNC_PIXEL, 8'd255, 32'h0000_0000, 32'h8080_8080);
    send_item(psc_pkg::FUNC_PIXEL, 8'd1,   32'h0000_0000, 32'h0000_0000);

    // Additive blend at zero opacity writes the destination back unchanged.
    wait_for_drain();
    set_config(1000, 1000, 1000, 1000, 0, 1, 0);
    send_item(psc_pkg::FUNC_PIXEL, 8'd128, 32'h0000_0000, 32'h1234_5678);

    // Alpha blend at zero opacity suppresses the write.
    wait_for_drain();
    set_config(1000, 1000, 1000, 1000, 0, 0, 0);
    send_item(psc_pkg::FUNC_PIXEL, 8'd2, 32'h0000_0000, 32'hFFFF_FFFF);

    // A half blend through an offset that wraps index 1 around to entry 0.
    wait_for_drain();
    set_config(1000, 1000, 1000, 1000, 500, 0, 255);
    send_item(psc_pkg::FUNC_PIXEL, 8'd1, 32'h0000_0000, 32'hFFFF_FFFF);

    // Fixed and random phases. Registers change only once the block has drained.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_drain();
      apply_setting(phase);
      if (phase >= NUM_PHASES - QUIET_PHASES) begin
        gap_pct   <= 0;
        stall_pct <= 0;
      end else if (phase == HOLD_PHASE) begin
        // Back-to-back transactions against a long receiver hold.
        gap_pct       <= 0;
        stall_pct     <= 0;
        hold_requests <= hold_requests + 1;
      end else begin
        gap_pct   <= idle_pct();
        stall_pct <= idle_pct();
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Once in the run, the sender stops halfway through a phase until
        // every result has come back, then carries on.
        if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) begin
          wait_for_drain();
        end
        send_random_item();
      end
    end

    // All stimulus is in. Wait for the last results, then keep watching so that
    // any stray extra transaction would be seen.
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (pixels_outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (2 * PIPE_LATENCY) @(negedge clk);

    if (mismatches == 0 && pixels_outstanding == 0) begin
      $display("tb_palette_sprite_compositor: PASS");
    end else begin
      $display("tb_palette_sprite_compositor: FAIL");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("tb_palette_sprite_compositor: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/psc_pkg.sv
src/psc_cfg.sv
src/psc_cond.sv
src/psc_pal_mem.sv
src/psc_blend.sv
src/palette_sprite_compositor.sv
verif/psc_pixel_checker.sv
verif/tb_palette_sprite_compositor.sv
